// File: hw/rtl/dmtr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmtr_pkg: shared types and constants for the trapezoid ramp core
// Event codes, register indexes, phase encoding and state/config records.
// ----------------------------------------------------------------------------
package dmtr_pkg;

	localparam int CFG_ADDR_W  = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int MAX_DUTY_W  = 10;
	localparam int TIME_W      = 32;
	localparam int RATE_W      = 32;
	localparam int FRAC_BITS   = 16;

	// event codes
	localparam logic [1:0] FUNC_REFRESH = 2'd0;
	localparam logic [1:0] FUNC_MOVE    = 2'd1;
	localparam logic [1:0] FUNC_STOP    = 2'd2;

	// register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_DUTY   = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_ACCEL_RATE = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_DECEL_RATE = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_DECEL_SPAN = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_REVERSED   = 3'd4;

	localparam logic [RATE_W-1:0] ACCEL_RATE_RST = 32'd6710886;
	localparam logic [RATE_W-1:0] DECEL_RATE_RST = 32'd6710886;
	localparam logic [TIME_W-1:0] DECEL_SPAN_RST = 32'd10;
	localparam logic [MAX_DUTY_W-1:0] MAX_DUTY_RST = 10'h3FF;

	// phase codes as seen on the result port
	localparam logic [1:0] PHASE_CODE_IDLE   = 2'd0;
	localparam logic [1:0] PHASE_CODE_ACCEL  = 2'd1;
	localparam logic [1:0] PHASE_CODE_CRUISE = 2'd2;
	localparam logic [1:0] PHASE_CODE_DECEL  = 2'd3;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_ACCEL  = 4'b0010,
		PH_CRUISE = 4'b0100,
		PH_DECEL  = 4'b1000
	} dmtr_phase_t;

	typedef struct packed {
		dmtr_phase_t       phase;
		logic              dir;
		logic [TIME_W-1:0] duration_ms;
		logic [TIME_W-1:0] start_ms;
		logic              pwm_on;
	} dmtr_state_t;

	typedef struct packed {
		logic [RATE_W-1:0] accel_rate;
		logic [RATE_W-1:0] decel_rate;
		logic [TIME_W-1:0] decel_span_ms;
		logic              reversed;
	} dmtr_cfg_t;

	function automatic logic [1:0] phase_code(input dmtr_phase_t ph);
		logic [1:0] code;
		case (ph)
			PH_ACCEL:  code = PHASE_CODE_ACCEL;
			PH_CRUISE: code = PHASE_CODE_CRUISE;
			PH_DECEL:  code = PHASE_CODE_DECEL;
			default:   code = PHASE_CODE_IDLE;
		endcase
		return code;
	endfunction

endpackage

// File: hw/rtl/dmtr_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmtr_cfg: configuration register file
// Write-only registers for duty ceiling, ramp rates, decel span and polarity.
// ----------------------------------------------------------------------------
module dmtr_cfg #(
	parameter int DUTY_BITS = 10
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wen,
	input  logic [dmtr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [dmtr_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic [DUTY_BITS-1:0]               max_duty,
	output dmtr_pkg::dmtr_cfg_t                cfg
);
	import dmtr_pkg::*;

	logic [DUTY_BITS-1:0] max_duty_q;
	dmtr_cfg_t            cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_duty_q          <= DUTY_BITS'(MAX_DUTY_RST);
			cfg_q.accel_rate    <= ACCEL_RATE_RST;
			cfg_q.decel_rate    <= DECEL_RATE_RST;
			cfg_q.decel_span_ms <= DECEL_SPAN_RST;
			cfg_q.reversed      <= 1'b0;
		end else if (cfg_wen) begin
			case (cfg_addr)
				REG_MAX_DUTY:   max_duty_q <= DUTY_BITS'(cfg_data[MAX_DUTY_W-1:0]);
				REG_ACCEL_RATE: cfg_q.accel_rate <= cfg_data[RATE_W-1:0];
				REG_DECEL_RATE: cfg_q.decel_rate <= cfg_data[RATE_W-1:0];
				REG_DECEL_SPAN: cfg_q.decel_span_ms <= cfg_data[TIME_W-1:0];
				REG_REVERSED:   cfg_q.reversed <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign max_duty = max_duty_q;
	assign cfg      = cfg_q;

endmodule

// File: hw/rtl/dmtr_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmtr_scale: UQ16.16 rate times milliseconds, saturated to the duty ceiling
// Product is truncated toward zero before the compare against the cap.
// ----------------------------------------------------------------------------
module dmtr_scale #(
	parameter int DUTY_BITS = 10
) (
	input  logic [dmtr_pkg::RATE_W-1:0] rate,
	input  logic [dmtr_pkg::TIME_W-1:0] ms,
	input  logic [DUTY_BITS-1:0]        cap,
	output logic [DUTY_BITS-1:0]        duty
);
	import dmtr_pkg::*;

	localparam int PROD_W = RATE_W + TIME_W;
	localparam int INT_W  = PROD_W - FRAC_BITS;

	logic [PROD_W-1:0] prod;
	logic [INT_W-1:0]  whole;
	logic              sat;

	assign prod  = {{TIME_W{1'b0}}, rate} * {{RATE_W{1'b0}}, ms};
	assign whole = prod[PROD_W-1:FRAC_BITS];
	assign sat   = whole > {{(INT_W-DUTY_BITS){1'b0}}, cap};
	assign duty  = sat ? cap : whole[DUTY_BITS-1:0];

endmodule

// File: hw/rtl/dmtr_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmtr_step: next-state logic for one event
// Phase transitions, move bookkeeping and the shared duty scaler.
// ----------------------------------------------------------------------------
module dmtr_step #(
	parameter int DUTY_BITS = 10
) (
	input  logic [1:0]                   func,
	input  logic [dmtr_pkg::TIME_W-1:0]  now_ms,
	input  logic signed [31:0]           move_ms,
	input  dmtr_pkg::dmtr_state_t        st,
	input  logic [DUTY_BITS-1:0]         duty,
	input  logic [DUTY_BITS-1:0]         max_duty,
	input  dmtr_pkg::dmtr_cfg_t          cfg,
	output dmtr_pkg::dmtr_state_t        st_next,
	output logic [DUTY_BITS-1:0]         duty_next
);
	import dmtr_pkg::*;

	logic [TIME_W-1:0]    elapsed;
	logic [TIME_W-1:0]    used;
	logic [TIME_W-1:0]    remain;
	logic [TIME_W-1:0]    sel_ms;
	logic [RATE_W-1:0]    sel_rate;
	logic [DUTY_BITS-1:0] scaled;
	logic                 cruise_end;
	logic [31:0]          mv_u;
	logic                 neg;
	logic [TIME_W-1:0]    mag;
	logic                 mv_dir;
	logic [TIME_W:0]      ext_sum;
	logic [TIME_W-1:0]    ext_dur;

	assign elapsed  = now_ms - st.start_ms;
	assign used     = (elapsed < st.duration_ms) ? elapsed : st.duration_ms;
	assign remain   = st.duration_ms - used;
	// one multiplier serves both ramps; only one phase is active at a time
	assign sel_ms   = (st.phase == PH_ACCEL) ? elapsed : remain;
	assign sel_rate = (st.phase == PH_ACCEL) ? cfg.accel_rate : cfg.decel_rate;

	dmtr_scale #(.DUTY_BITS(DUTY_BITS)) u_scale (
		.rate (sel_rate),
		.ms   (sel_ms),
		.cap  (max_duty),
		.duty (scaled)
	);

	// compared without wrap
	assign cruise_end = ({1'b0, elapsed} + {1'b0, cfg.decel_span_ms})
		>= {1'b0, st.duration_ms};

	assign mv_u    = move_ms;
	assign neg     = mv_u[31];
	assign mag     = neg ? (~mv_u + 32'd1) : mv_u;
	assign mv_dir  = ~neg ^ cfg.reversed;
	assign ext_sum = {1'b0, st.duration_ms} + {1'b0, mag};
	assign ext_dur = ext_sum[TIME_W] ? {TIME_W{1'b1}} : ext_sum[TIME_W-1:0];

	always_comb begin
		st_next   = st;
		duty_next = duty;
		case (func)
			FUNC_REFRESH: begin
				case (st.phase)
					PH_ACCEL: begin
						duty_next     = scaled;
						st_next.pwm_on = 1'b1;
						if (scaled >= max_duty) st_next.phase = PH_CRUISE;
					end
					PH_CRUISE: begin
						if (cruise_end) st_next.phase = PH_DECEL;
					end
					PH_DECEL: begin
						duty_next     = scaled;
						st_next.pwm_on = 1'b1;
						if (scaled == '0) st_next.phase = PH_IDLE;
					end
					default: ;
				endcase
			end
			FUNC_MOVE: begin
				if (mv_u != 32'd0) begin
					if (st.phase == PH_IDLE) begin
						st_next.dir         = mv_dir;
						st_next.duration_ms = mag;
						st_next.start_ms    = now_ms;
						st_next.phase       = PH_ACCEL;
					end else if (mv_dir == st.dir) begin
						st_next.duration_ms = ext_dur;
					end
				end
			end
			FUNC_STOP: begin
				if (st.phase != PH_IDLE) begin
					st_next.pwm_on = 1'b0;
					st_next.phase  = PH_IDLE;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: hw/rtl/dc_motor_trapezoid_ramp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dc_motor_trapezoid_ramp_core: trapezoidal velocity profile for a DC motor
// Timestamped events (refresh, move, stop) drive an idle / accelerate /
// cruise / decelerate sequence and produce duty, PWM enable and direction.
//
// Input channel: in_valid / in_stall with func, now_ms, move_ms. Every
// accepted event yields exactly one result transaction on out_valid /
// out_stall carrying phase, duty, pwm_enabled and dir_pin after the event.
// An accepted event is registered in the input stage, evaluated by the step logic
// and presented at out_valid from the result register. Throughput: one event
// per cycle while out_stall is low. The limiting path is the single shared
// 32x32 rate multiplier plus saturation and phase compare in the step logic.
// When the receiver stalls, the result register holds and the input stage
// takes one more event; after that in_stall rises until the result drains.
// Reset clears the profile state to idle, duty and PWM off, and loads the
// configuration defaults. Configuration writes go through cfg_wen/cfg_addr/
// cfg_data and are expected only while no event is in flight.
// ----------------------------------------------------------------------------
module dc_motor_trapezoid_ramp_core #(
	parameter int DUTY_BITS = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [dmtr_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [dmtr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      func,
	input  logic [31:0]                     now_ms,
	input  logic signed [31:0]              move_ms,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      phase,
	output logic [DUTY_BITS-1:0]            duty,
	output logic                            pwm_enabled,
	output logic                            dir_pin
);
	import dmtr_pkg::*;

	logic [DUTY_BITS-1:0] max_duty;
	dmtr_cfg_t            cfg;

	logic                 valid_s1;
	logic [1:0]           func_s1;
	logic [TIME_W-1:0]    now_ms_s1;
	logic signed [31:0]   move_ms_s1;

	dmtr_state_t          st_q;
	dmtr_state_t          st_next;
	logic [DUTY_BITS-1:0] duty_q;
	logic [DUTY_BITS-1:0] duty_next;

	logic                 valid_s2;
	logic [1:0]           phase_s2;
	logic [DUTY_BITS-1:0] duty_s2;
	logic                 pwm_s2;
	logic                 dir_s2;

	logic                 adv_s2;
	logic                 ready_s1;
	logic                 in_acc;
	logic                 fire;

	dmtr_cfg #(.DUTY_BITS(DUTY_BITS)) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.max_duty (max_duty),
		.cfg      (cfg)
	);

	assign adv_s2   = !valid_s2 || !out_stall;
	assign ready_s1 = !valid_s1 || adv_s2;
	assign in_acc   = in_valid && ready_s1;
	assign fire     = valid_s1 && adv_s2;
	assign in_stall = !ready_s1;

	dmtr_step #(.DUTY_BITS(DUTY_BITS)) u_step (
		.func      (func_s1),
		.now_ms    (now_ms_s1),
		.move_ms   (move_ms_s1),
		.st        (st_q),
		.duty      (duty_q),
		.max_duty  (max_duty),
		.cfg       (cfg),
		.st_next   (st_next),
		.duty_next (duty_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_s1    <= func;
			now_ms_s1  <= now_ms;
			move_ms_s1 <= move_ms;
		end
		if (fire) begin
			phase_s2 <= phase_code(st_next.phase);
			duty_s2  <= duty_next;
			pwm_s2   <= st_next.pwm_on;
			dir_s2   <= st_next.dir;
		end
	end

	// profile state advances once per evaluated event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase       <= PH_IDLE;
			st_q.dir         <= 1'b0;
			st_q.duration_ms <= '0;
			st_q.start_ms    <= '0;
			st_q.pwm_on      <= 1'b0;
			duty_q           <= '0;
		end else if (fire) begin
			st_q   <= st_next;
			duty_q <= duty_next;
		end
	end

	assign out_valid   = valid_s2;
	assign phase       = phase_s2;
	assign duty        = duty_s2;
	assign pwm_enabled = pwm_s2;
	assign dir_pin     = dir_s2;

endmodule

// File: hw/rtl/dmtr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmtr_checker: port-level checks for the trapezoid ramp core
// Tracks transactions in flight and the last accepted result transaction.
// ----------------------------------------------------------------------------
module dmtr_checker #(
	parameter int DUTY_BITS = 10
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [1:0]                      phase,
	input logic [DUTY_BITS-1:0]            duty,
	input logic                            pwm_enabled
);
	import dmtr_pkg::*;

	logic [1:0]           inflight_q;
	logic [1:0]           last_phase_q;
	logic [DUTY_BITS-1:0] last_duty_q;
	logic                 in_acc;
	logic                 out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q   <= '0;
			last_phase_q <= PHASE_CODE_IDLE;
			last_duty_q  <= '0;
		end else begin
			inflight_q <= inflight_q + {1'b0, in_acc} - {1'b0, out_acc};
			if (out_acc) begin
				last_phase_q <= phase;
				last_duty_q  <= duty;
			end
		end
	end

	// a held result does not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(phase) && $stable(duty)
			&& $stable(pwm_enabled))
		else $error("result changed while stalled");

	// two storage slots: input stage and result register
	a_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q != 2'd3 && (!out_valid || inflight_q != 2'd0))
		else $error("transaction count out of range");

	// duty is only written while ramping, so it holds from cruise to cruise
	a_cruise_duty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && phase == PHASE_CODE_CRUISE && last_phase_q == PHASE_CODE_CRUISE
			|-> duty == last_duty_q)
		else $error("duty changed while cruising");

	a_run_pwm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (phase == PHASE_CODE_CRUISE || phase == PHASE_CODE_DECEL)
			|-> pwm_enabled)
		else $error("PWM off while cruising or decelerating");

endmodule

bind dc_motor_trapezoid_ramp_core dmtr_checker #(.DUTY_BITS(DUTY_BITS)) u_dmtr_checker (.*);
